@@ hw/rtl/b64d_pkg.sv @@
// Shared types and constants for the Base64 decoder.
package b64d_pkg;

  // Depth of the queue between the front and back parts.
  localparam int QDepth = 4;
  localparam int QAddrW = $clog2(QDepth);
  localparam int QCountW = $clog2(QDepth + 1);

  // Width of a decoded six-bit value.
  localparam int SextetW = 6;

  // Classified character as it travels from front to back.
  typedef struct packed {
    logic               term;    // outside the alphabet: ends the message
    logic [SextetW-1:0] sextet;  // decoded six-bit value, zero when term
  } item_t;

  // Group phase codes.
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;
  localparam logic [1:0] PH_FOURTH = 2'd3;

endpackage

@@ hw/rtl/base64_url_decoder_unit.sv @@
// Top level of the streaming Base64 decoder (URL-safe and standard alphabets).
//
// Usage:
//   Input channel in_valid/in_ready carries one character (char_code) per word.
//   Output channel out_valid/out_ready carries one result word: data_byte,
//   byte_valid, last and total_bytes. A character outside the alphabet ends
//   the message and always gives a word with last set.
//   cfg_write/cfg_data load max_output_bytes (reset 65535); write it only while
//   the block is idle. Bytes past that count are dropped until the terminator.
// Throughput: one character per cycle, sustained while out_ready stays high.
// Path: a character passes from the front stage through the queue into the
//   output register, whose word drives the outputs.
// Structure: the front classifies characters into six-bit values and pushes
//   them into a four-entry queue; the back holds group phase, prior value and
//   byte count, and pops the queue whenever its output register is free or
//   being taken. Data characters that complete no byte pop without a result.
// Reset: clears the queue, the group state and the count, and sets the limit
//   to 65535. Stall: with out_ready low the output word holds, the queue fills,
//   and in_ready drops once the queue and the front stage are full.
module base64_url_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic        byte_valid,
  output logic        last,
  output logic [15:0] total_bytes
);
  import b64d_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  logic  q_valid;
  item_t head;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .last        (last),
    .total_bytes (total_bytes)
  );

endmodule

@@ hw/rtl/b64d_front.sv @@
// Front part: accepts characters and maps them to six-bit values.
module b64d_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     char_code,
  output logic           push,
  output b64d_pkg::item_t push_item,
  input  logic           q_full
);
  import b64d_pkg::*;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_USCORE  = 8'h5f;
  localparam logic [7:0] CH_SLASH   = 8'h2f;

  item_t cls;
  item_t stage;
  logic  stage_valid;
  logic  take;

  always_comb begin
    cls = '0;
    priority if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z) begin
      cls.sextet = SextetW'(char_code - CH_UPPER_A);
    end else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
      cls.sextet = SextetW'(char_code - CH_LOWER_A + 8'd26);
    end else if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      cls.sextet = SextetW'(char_code - CH_ZERO + 8'd52);
    end else if (char_code == CH_MINUS || char_code == CH_PLUS) begin
      cls.sextet = SextetW'(62);
    end else if (char_code == CH_USCORE || char_code == CH_SLASH) begin
      cls.sextet = SextetW'(63);
    end else begin
      cls.term = 1'b1;
    end
  end

  // One-entry stage; drains into the queue whenever it has room.
  assign push      = stage_valid && !q_full;
  assign push_item = stage;
  assign in_ready  = !stage_valid || !q_full;
  assign take      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage <= cls;
    end
  end

endmodule

@@ hw/rtl/b64d_queue.sv @@
// Small flop queue between the front and back parts.
module b64d_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64d_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output b64d_pkg::item_t head
);
  import b64d_pkg::*;

  item_t              slots [QDepth];
  logic [QAddrW-1:0]  wr_ptr;
  logic [QAddrW-1:0]  rd_ptr;
  logic [QCountW-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == QCountW'(QDepth));
  assign q_valid = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAddrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAddrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ hw/rtl/b64d_back.sv @@
// Back part: group state, byte assembly, capacity limit and output register.
module b64d_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [15:0]     cfg_data,
  input  logic            q_valid,
  input  b64d_pkg::item_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      data_byte,
  output logic            byte_valid,
  output logic            last,
  output logic [15:0]     total_bytes
);
  import b64d_pkg::*;

  logic [15:0]        max_output_bytes;
  logic [1:0]         phase;
  logic [SextetW-1:0] prior;
  logic [15:0]        count;

  logic        room;
  logic        have;
  logic        emit;
  logic [7:0]  byte_next;
  logic [15:0] count_inc;

  assign pop       = q_valid && (!out_valid || out_ready);
  assign room      = count < max_output_bytes;
  assign count_inc = count + 16'd1;

  always_comb begin
    byte_next = '0;
    have      = 1'b0;
    if (head.term) begin
      have      = (phase == PH_SECOND) && room;
      byte_next = have ? {prior, 2'b11} : 8'd0;
    end else begin
      unique case (phase)
        PH_SECOND: byte_next = {prior, head.sextet[5:4]};
        PH_THIRD:  byte_next = {prior[3:0], head.sextet[5:2]};
        PH_FOURTH: byte_next = {prior[1:0], head.sextet};
        default:   byte_next = '0;
      endcase
      have = (phase != PH_FIRST) && room;
    end
  end

  // A terminator always yields a result; a data character only with a byte.
  assign emit = pop && (head.term || have);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output_bytes <= 16'hffff;
      phase            <= PH_FIRST;
      prior            <= '0;
      count            <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        max_output_bytes <= cfg_data;
      end
      if (pop) begin
        if (head.term) begin
          phase <= PH_FIRST;
          prior <= '0;
          count <= '0;
        end else begin
          phase <= phase + 2'd1;
          prior <= head.sextet;
          if (have) begin
            count <= count_inc;
          end
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      data_byte   <= byte_next;
      byte_valid  <= have;
      last        <= head.term;
      total_bytes <= have ? count_inc : count;
    end
  end

endmodule
